// ----- rtl/core/text_console_cell_writer_macros.svh -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_macros.svh
// Assertion shorthands shared by the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TCCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Codes and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  typedef logic [15:0] cell_t;

  localparam int READ_INDEX_W = 11;

  // transaction kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register index (word address bit of the APB port)
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam int         TAB_EXTRA  = 5;

  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam cell_t      RESET_CELL = 16'h0720;

endpackage

// ----- rtl/core/text_console_cell_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Glass-teletype text console: cursor plus a ROWS x COLUMNS screen memory.
// ----------------------------------------------------------------------------
// The screen lives in one synchronous RAM of COLUMNS*ROWS 16-bit cells
// (character in the low byte, attribute in the high byte). Rows are kept as
// a ring: top_base points at the physical start of logical row 0, so a
// scroll moves no data, it only advances top_base and wipes the row slot
// that becomes the new bottom row. Steps per transaction, set by the single
// write port and the registered read port of that RAM:
//   - put of a character that does not scroll: the cell write alone
//   - read of a cell: address cycle, then registered RAM data
//   - put that scrolls: the cell write, then the bottom row is zeroed one
//     cell per cycle; input stays blocked until that is done
// After reset the RAM is filled with space/light-grey (0x0720) one cell per
// cycle, COLUMNS*ROWS cells (2000 at the default size); in_ready stays low
// for that time, while APB writes are taken as usual. One transaction is in
// flight at a time; when the block is idle, a new one is taken in the same
// cycle the previous result leaves the output register. Reads never overlap
// a write, so the RAM needs no forwarding.
module text_console_cell_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  character,
  input  logic [10:0] read_index,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [15:0] cell_word,
  output logic        scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int NW    = CW + 1;   // column plus tab step never overflows this
  localparam int IW    = ((AW > READ_INDEX_W) ? AW : READ_INDEX_W) + 1;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,   // reset fill of the screen RAM
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,   // waiting on RAM read data
    ST_CLEAR = 4'b1000    // zeroing the new bottom row after a scroll
  } state_t;

  state_t          state;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [AW-1:0]   row_base;     // physical start of the cursor row
  logic [AW-1:0]   top_base;     // physical start of logical row 0
  logic [AW-1:0]   sweep_addr;
  logic [AW-1:0]   sweep_last;
  logic [7:0]      attr;

  cell_t           screen [CELLS];
  cell_t           rd_data;
  logic            rd_oob;

  // Advance a row slot pointer by one row, wrapping at the end of the RAM.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] base);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(COLUMNS);
    if (s >= (AW+1)'(CELLS)) s = '0;
    return s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic accept, put_go, read_go;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign put_go   = accept && (kind == KIND_PUT);
  assign read_go  = accept && (kind == KIND_READ);

  // --------------------------------------------------------------------------
  // Cursor update for a put
  // --------------------------------------------------------------------------
  logic          is_nl, is_tab, wrap, scroll_hit;
  logic [7:0]    shown;
  logic [NW-1:0] col_step;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    is_nl    = (character == CH_NEWLINE);
    is_tab   = (character == CH_TAB);
    shown    = (is_nl || is_tab) ? CH_SPACE : character;
    col_step = NW'(col) + NW'(1) + (is_tab ? NW'(TAB_EXTRA) : NW'(0));
    wrap     = is_nl || (col_step >= NW'(COLUMNS));
    scroll_hit = wrap && (row == RW'(ROWS - 1));
    col_next = wrap ? '0 : col_step[CW-1:0];
    row_next = (wrap && !scroll_hit) ? row + RW'(1) : row;
  end

  // --------------------------------------------------------------------------
  // Read address: logical index rotated by top_base
  // --------------------------------------------------------------------------
  logic [IW-1:0] ri_ext, ri_sum, ri_phys;
  logic          ri_oob;
  logic [AW-1:0] rd_addr;

  always_comb begin
    ri_ext  = IW'(read_index);
    ri_sum  = ri_ext + IW'(top_base);
    ri_oob  = (ri_ext >= IW'(CELLS));
    ri_phys = (ri_sum >= IW'(CELLS)) ? ri_sum - IW'(CELLS) : ri_sum;
    rd_addr = ri_phys[AW-1:0];
  end

  // --------------------------------------------------------------------------
  // Screen RAM write port
  // --------------------------------------------------------------------------
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = put_go;
        mem_waddr = row_base + AW'(col);
        mem_wdata = {attr, shown};
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    rd_data <= screen[rd_addr];
  end

  // --------------------------------------------------------------------------
  // APB register
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? {24'b0, attr} : 32'b0;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep_addr <= '0;
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
      top_base   <= '0;
      attr       <= RESET_ATTR;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_TEXT_ATTRIBUTE)) begin
        attr <= pwdata[7:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (put_go) begin
            out_valid <= 1'b1;
            col       <= col_next;
            row       <= row_next;
            if (scroll_hit) begin
              // old top row slot becomes the bottom row
              top_base   <= next_slot(top_base);
              row_base   <= top_base;
              sweep_addr <= top_base;
              sweep_last <= top_base + AW'(COLUMNS - 1);
              state      <= ST_CLEAR;
            end else if (wrap) begin
              row_base <= next_slot(row_base);
            end
          end else if (read_go) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_CLEAR: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == sweep_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (read_go) begin
      rd_oob <= ri_oob;
    end
    if (put_go) begin
      cursor_column <= 7'(col_next);
      cursor_row    <= 5'(row_next);
      cell_word     <= '0;
      scrolled      <= scroll_hit;
    end else if (state == ST_READ) begin
      cursor_column <= 7'(col);
      cursor_row    <= 5'(row);
      cell_word     <= rd_oob ? 16'h0000 : rd_data;
      scrolled      <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on the text console cell writer.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_macros.svh"

module tccw_checker
  import tccw_pkg::*;
#(
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  cursor_column,
  input logic [4:0]  cursor_row,
  input logic [15:0] cell_word,
  input logic        scrolled
);

  // screen fill runs right after reset, so no transaction is taken then
  `TCCW_ASSERT_ALWAYS(a_no_take_after_rst, $past(rst) |-> !in_ready, "input taken during fill")

  `TCCW_ASSERT(a_read_latency, (in_valid && in_ready && kind == KIND_READ) |=> !out_valid ##1 out_valid, "read result not two cycles later")

  `TCCW_ASSERT(a_put_result, (in_valid && in_ready && kind == KIND_PUT) |=> out_valid && cell_word == 16'h0000, "put result missing or nonzero cell")

  `TCCW_ASSERT(a_scroll_cursor, (out_valid && scrolled) |-> cursor_column == 7'd0 && cursor_row == 5'(ROWS - 1), "scroll left cursor off the last row start")

  `TCCW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid && $stable(cell_word) && $stable(cursor_column), "stalled result changed")

endmodule

bind text_console_cell_writer tccw_checker #(.ROWS(ROWS)) u_tccw_checker (.*);
